// ----- rtl/core/trle_pkg.sv -----
`default_nettype none
package trle_pkg;

    localparam int MAP_ENTRIES_DEFAULT = 256;
    localparam int CMD_QUEUE_DEPTH     = 4;
    localparam int OUT_QUEUE_DEPTH     = 4;

    localparam logic OP_PIXEL_BYTE = 1'b0;
    localparam logic OP_MAP_WRITE  = 1'b1;

    // word index of each configuration register
    localparam logic REG_RLE_ENABLE   = 1'b0;
    localparam logic REG_PIXEL_FORMAT = 1'b1;

    localparam logic [2:0] PIXEL_FORMAT_RESET = 3'd3;

    typedef enum logic [2:0] {
        FMT_GREY8  = 3'd0,
        FMT_CMAP8  = 3'd1,
        FMT_RGB555 = 3'd2,
        FMT_BGR24  = 3'd3,
        FMT_BGRA32 = 3'd4
    } fmt_t;

    // one entry of the queue between front and back
    typedef struct packed {
        logic        is_write;
        logic [31:0] data;      // pixel bytes {b3,b2,b1,b0} or {index, entry}
        logic [7:0]  count;
    } cmd_t;

    typedef struct packed {
        logic [31:0] argb;
        logic [7:0]  repeat_count;
    } result_t;

    localparam logic [7:0] WIDEN5 [0:31] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    function automatic logic [2:0] bytes_per_pixel(input logic [2:0] fmt);
        logic [2:0] n;
        unique case (fmt_t'(fmt))
            FMT_GREY8:  n = 3'd1;
            FMT_CMAP8:  n = 3'd1;
            FMT_RGB555: n = 3'd2;
            FMT_BGRA32: n = 3'd4;
            default:    n = 3'd3;
        endcase
        return n;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/trle_fifo.sv -----
`default_nettype none
module trle_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             rd_en,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/trle_ram.sv -----
`default_nettype none
module trle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0]      rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/trle_front.sv -----
`default_nettype none
module trle_front (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rle_enable,
    input  wire logic [2:0]  pixel_format,
    input  wire logic        accept,
    input  wire logic        operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  map_index,
    input  wire logic [23:0] map_entry,
    output logic             cmd_push,
    output trle_pkg::cmd_t   cmd
);
    logic       need_header_reg, need_header_next;
    logic [6:0] raw_left_reg, raw_left_next;
    logic [7:0] repeat_pending_reg, repeat_pending_next;
    logic [1:0] byte_pos_reg, byte_pos_next;
    logic [7:0] pixel_bytes_reg [4];
    logic [7:0] pixel_bytes_next [4];
    logic [7:0] merged [4];

    always_comb
    begin
        need_header_next    = need_header_reg;
        raw_left_next       = raw_left_reg;
        repeat_pending_next = repeat_pending_reg;
        byte_pos_next       = byte_pos_reg;
        pixel_bytes_next    = pixel_bytes_reg;
        merged              = pixel_bytes_reg;
        merged[byte_pos_reg] = data_byte;
        cmd_push            = 1'b0;
        cmd.is_write        = 1'b0;
        cmd.data            = {merged[3], merged[2], merged[1], merged[0]};
        cmd.count           = 8'd1;

        if (accept)
        begin
            if (operation == trle_pkg::OP_MAP_WRITE)
            begin
                cmd_push     = 1'b1;
                cmd.is_write = 1'b1;
                cmd.data     = {map_index, map_entry};
            end
            else if (rle_enable && need_header_reg)
            begin
                need_header_next = 1'b0;
                if (data_byte[7])
                begin
                    repeat_pending_next = {1'b0, data_byte[6:0]} + 8'd1;
                    raw_left_next       = '0;
                end
                else
                begin
                    repeat_pending_next = 8'd1;
                    raw_left_next       = data_byte[6:0];
                end
            end
            else
            begin
                pixel_bytes_next = merged;
                if (({1'b0, byte_pos_reg} + 3'd1) < trle_pkg::bytes_per_pixel(pixel_format))
                begin
                    byte_pos_next = byte_pos_reg + 2'd1;
                end
                else
                begin
                    byte_pos_next = '0;
                    cmd_push      = 1'b1;
                    if (rle_enable)
                    begin
                        cmd.count           = repeat_pending_reg;
                        repeat_pending_next = 8'd1;
                        if (raw_left_reg == '0)
                        begin
                            need_header_next = 1'b1;
                        end
                        else
                        begin
                            raw_left_next = raw_left_reg - 7'd1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            need_header_reg    <= 1'b1;
            raw_left_reg       <= '0;
            repeat_pending_reg <= 8'd1;
            byte_pos_reg       <= '0;
            pixel_bytes_reg    <= '{default: 8'd0};
        end
        else
        begin
            need_header_reg    <= need_header_next;
            raw_left_reg       <= raw_left_next;
            repeat_pending_reg <= repeat_pending_next;
            byte_pos_reg       <= byte_pos_next;
            pixel_bytes_reg    <= pixel_bytes_next;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/trle_back.sv -----
`default_nettype none
module trle_back #(
    parameter int MAP_ENTRIES = trle_pkg::MAP_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [2:0]  pixel_format,
    input  wire trle_pkg::cmd_t cmd,
    input  wire logic        cmd_empty,
    output logic             cmd_pop,
    input  wire logic        pop,
    output logic             empty,
    output logic [31:0]      argb,
    output logic [7:0]       repeat_count
);
    localparam int AW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;

    logic              s1_valid_reg, s1_valid_next;
    logic [31:0]       s1_bytes_reg;
    logic [7:0]        s1_count_reg;
    logic              s1_in_range_reg;
    logic              out_full;
    logic              advance;
    logic              ram_we, ram_re;
    logic [23:0]       ram_rdata;
    logic [7:0]        rd_index, wr_index;
    logic              rd_in_range, wr_in_range;
    logic [15:0]       t555;
    logic [23:0]       rgb;
    trle_pkg::result_t res_in, res_out;

    assign wr_index    = cmd.data[31:24];
    assign rd_index    = cmd.data[7:0];
    assign wr_in_range = ({1'b0, wr_index} < 9'(MAP_ENTRIES));
    assign rd_in_range = ({1'b0, rd_index} < 9'(MAP_ENTRIES));

    // the read stage may move on when it is empty or its result can leave
    assign advance = !s1_valid_reg || !out_full;
    assign cmd_pop = !cmd_empty && advance;
    assign ram_we  = cmd_pop && cmd.is_write && wr_in_range;
    assign ram_re  = cmd_pop && !cmd.is_write;

    trle_ram #(
        .WIDTH(24),
        .DEPTH(MAP_ENTRIES),
        .AW   (AW)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(wr_index[AW-1:0]),
        .wdata(cmd.data[23:0]),
        .re   (ram_re),
        .raddr(rd_index[AW-1:0]),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (ram_re)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            s1_bytes_reg    <= cmd.data;
            s1_count_reg    <= cmd.count;
            s1_in_range_reg <= rd_in_range;
        end
    end

    always_comb
    begin
        t555 = s1_bytes_reg[15:0];
        unique case (trle_pkg::fmt_t'(pixel_format))
            trle_pkg::FMT_GREY8:
                rgb = {3{s1_bytes_reg[7:0]}};
            trle_pkg::FMT_CMAP8:
                rgb = s1_in_range_reg ? ram_rdata : 24'd0;
            trle_pkg::FMT_RGB555:
                rgb = {trle_pkg::WIDEN5[t555[14:10]],
                       trle_pkg::WIDEN5[t555[9:5]],
                       trle_pkg::WIDEN5[t555[4:0]]};
            default:
                rgb = s1_bytes_reg[23:0];
        endcase
        res_in.argb         = {8'hFF, rgb};
        res_in.repeat_count = s1_count_reg;
    end

    trle_fifo #(
        .WIDTH($bits(trle_pkg::result_t)),
        .DEPTH(trle_pkg::OUT_QUEUE_DEPTH)
    ) u_out_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (s1_valid_reg),
        .wr_data(res_in),
        .full   (out_full),
        .rd_en  (pop),
        .rd_data(res_out),
        .empty  (empty)
    );

    assign argb         = res_out.argb;
    assign repeat_count = res_out.repeat_count;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_full |=> s1_valid_reg && $stable(s1_bytes_reg))
        else $error("read stage lost a pixel while the result queue was full");

    a_we_re_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_we && ram_re))
        else $error("table write and read issued for one command");

    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && s1_valid_reg |-> !out_full)
        else $error("command taken with no room downstream");

endmodule
`default_nettype wire

// ----- rtl/core/targa_rle_pixel_decoder.sv -----
`default_nettype none
// Targa pixel-stream decoder: bytes in, 32-bit ARGB pixels with repeat counts out.
// Input queue side: drive operation/data_byte/map_index/map_entry with push; a transfer
// happens at a clock edge with push high and full low. operation 0 feeds the next
// stream byte, operation 1 writes one colour table entry (no result).
// Result queue side: while empty is low, argb and repeat_count hold the oldest
// result; a transfer happens at an edge with pop high and empty low.
// Configuration over APB: rle_enable at byte 0, pixel_format at byte 4; write only
// while no item is in flight. pready is tied high.
// Throughput is one item per cycle while full is low. The last byte of a pixel reaches
// the result ports through the command queue, the registered colour table read stage
// and the result queue, and is then taken with pop.
// When pop is held low the result queue fills, the table read stage holds, the
// command queue fills behind it and full rises; nothing is dropped.
// Reset clears packet state (next byte is a packet header), the byte position and
// both queues; the colour table keeps no reset and must be written before use.
module targa_rle_pixel_decoder #(
    parameter int MAP_ENTRIES = trle_pkg::MAP_ENTRIES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        push,
    output logic             full,
    input  wire logic        operation,
    input  wire logic [7:0]  data_byte,
    input  wire logic [7:0]  map_index,
    input  wire logic [23:0] map_entry,
    input  wire logic        pop,
    output logic             empty,
    output logic [31:0]      argb,
    output logic [7:0]       repeat_count
);
    logic           rle_enable_reg;
    logic [2:0]     pixel_format_reg;
    logic           cfg_write;
    logic           accept;
    logic           cmd_push, cmd_pop, cmd_empty;
    trle_pkg::cmd_t cmd_in, cmd_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rle_enable_reg   <= 1'b0;
            pixel_format_reg <= trle_pkg::PIXEL_FORMAT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                trle_pkg::REG_RLE_ENABLE:   rle_enable_reg   <= pwdata[0];
                trle_pkg::REG_PIXEL_FORMAT: pixel_format_reg <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            trle_pkg::REG_RLE_ENABLE:   prdata = {31'd0, rle_enable_reg};
            trle_pkg::REG_PIXEL_FORMAT: prdata = {29'd0, pixel_format_reg};
            default:                    prdata = '0;
        endcase
    end

    assign accept = push && !full;

    trle_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rle_enable  (rle_enable_reg),
        .pixel_format(pixel_format_reg),
        .accept      (accept),
        .operation   (operation),
        .data_byte   (data_byte),
        .map_index   (map_index),
        .map_entry   (map_entry),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    trle_fifo #(
        .WIDTH($bits(trle_pkg::cmd_t)),
        .DEPTH(trle_pkg::CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_push),
        .wr_data(cmd_in),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_data(cmd_out),
        .empty  (cmd_empty)
    );

    trle_back #(
        .MAP_ENTRIES(MAP_ENTRIES)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_format(pixel_format_reg),
        .cmd         (cmd_out),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .pop         (pop),
        .empty       (empty),
        .argb        (argb),
        .repeat_count(repeat_count)
    );

endmodule
`default_nettype wire
